@@ rtl/core/ecpu_pkg.sv @@
// Shared types, opcode codes, flag masks and helper functions of the execute unit.
// No dependencies; the front end, back end and top level in rtl/core use this package.
package ecpu_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] FL_N = 8'h80;
  localparam logic [7:0] FL_R = 8'h20;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] SP_RESET = 8'hFF;
  localparam logic [7:0] FLAGS_RESET = 8'h20;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI, OP_BNE, OP_BPL,
    OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP, OP_CPX, OP_CPY,
    OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX, OP_INY, OP_JMP, OP_JSR, OP_LDA,
    OP_LDX, OP_LDY, OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_ROL,
    OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA, OP_STX, OP_STY,
    OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
  } op_t;

  // Stack class: last is the index of the final back-end step of the instruction.
  typedef struct packed {
    logic       is_push;
    logic       is_pull;
    logic [1:0] last;
  } cls_t;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [7:0]  operand;
    logic        on_acc;
    logic [15:0] target;
    logic [15:0] pc;
    cls_t        cls;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fstat_t;

  typedef struct packed {
    logic mid;
    logic pop;
  } bstat_t;

  function automatic cls_t classify(input logic [5:0] op);
    cls_t c;
    c = '{is_push: 1'b0, is_pull: 1'b0, last: 2'd0};
    case (op)
      OP_PHA, OP_PHP: c = '{is_push: 1'b1, is_pull: 1'b0, last: 2'd0};
      OP_JSR:         c = '{is_push: 1'b1, is_pull: 1'b0, last: 2'd1};
      OP_BRK:         c = '{is_push: 1'b1, is_pull: 1'b0, last: 2'd2};
      OP_PLA, OP_PLP: c = '{is_push: 1'b0, is_pull: 1'b1, last: 2'd1};
      OP_RTS:         c = '{is_push: 1'b0, is_pull: 1'b1, last: 2'd2};
      OP_RTI:         c = '{is_push: 1'b0, is_pull: 1'b1, last: 2'd3};
      default:        c = '{is_push: 1'b0, is_pull: 1'b0, last: 2'd0};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    return {v[7], p[6:2], (v == 8'h00), p[0]};
  endfunction

endpackage

@@ rtl/core/ecpu_instr_if.sv @@
// Instruction channel: valid/ready handshake with the decoded instruction payload.
// Depends on nothing.
interface ecpu_instr_if;
  logic        valid;
  logic        ready;
  logic [5:0]  opcode;
  logic [7:0]  operand;
  logic        on_accumulator;
  logic [15:0] target_address;
  logic [15:0] current_pc;

  modport source(output valid, opcode, operand, on_accumulator, target_address, current_pc,
                 input ready);
  modport sink(input valid, opcode, operand, on_accumulator, target_address, current_pc,
               output ready);
endinterface

@@ rtl/core/ecpu_result_if.sv @@
// Result channel: valid/ready handshake with PC, registers, flags and write-back.
// Depends on nothing.
interface ecpu_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        mem_write;
  logic [7:0]  mem_data;
  logic [7:0]  acc_value;
  logic [7:0]  x_value;
  logic [7:0]  y_value;
  logic [7:0]  sp_value;
  logic [7:0]  flags_value;

  modport source(output valid, next_pc, mem_write, mem_data, acc_value, x_value, y_value,
                 sp_value, flags_value, input ready);
  modport sink(input valid, next_pc, mem_write, mem_data, acc_value, x_value, y_value,
               sp_value, flags_value, output ready);
endinterface

@@ rtl/core/eight_bit_cpu_execute_unit.sv @@
// Execute unit top level: instruction queue front end feeding the execute back end.
// An accepted instruction beat is written into the queue; with an idle back end it is then
// executed from the queue head and its result beat is presented from the result register,
// after any extra stack steps described below. Throughput: one instruction per cycle for
// register, branch and memory operations while the result channel accepts beats; stack
// operations hold the back end through a step for each stack byte and a further step for pulls.
// Reset: A, X, Y zero, SP 0xFF, flags 0x20, break vector 0, stack page reads as zero.
module eight_bit_cpu_execute_unit #(
  parameter int QUEUE_DEPTH = ecpu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [15:0]   cfg_data,
  ecpu_instr_if.sink    instr,
  ecpu_result_if.source result
);
  ecpu_pkg::entry_t head;
  ecpu_pkg::fstat_t fstat;
  ecpu_pkg::bstat_t bstat;
  logic pop;

  ecpu_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .instr(instr), .pop(pop), .head(head), .stat(fstat)
  );

  ecpu_back u_back (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data), .head(head),
    .qstat(fstat), .pop(pop), .stat(bstat), .result(result)
  );

`ifndef SYNTHESIS
  // A stack sequence in progress keeps its instruction at the queue head.
  assert property (@(posedge clk) disable iff (rst) bstat.mid |-> fstat.valid)
    else $error("stack sequence running with an empty queue");
  // Retiring an instruction always presents a result beat next cycle.
  assert property (@(posedge clk) disable iff (rst) bstat.pop |=> result.valid)
    else $error("retired instruction produced no result beat");
  // The back end only retires what the queue holds.
  assert property (@(posedge clk) disable iff (rst) bstat.pop |-> fstat.valid)
    else $error("pop from an empty queue");
  // A full queue refuses new beats.
  assert property (@(posedge clk) disable iff (rst) fstat.full |-> !instr.ready)
    else $error("queue accepts beats while full");
`endif
endmodule

@@ rtl/core/ecpu_front.sv @@
// Front end: accepts instruction beats, classifies stack use, and queues them.
// Depends on ecpu_pkg and ecpu_instr_if.
module ecpu_front #(
  parameter int DEPTH = ecpu_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  ecpu_instr_if.sink           instr,
  input  logic                 pop,
  output ecpu_pkg::entry_t     head,
  output ecpu_pkg::fstat_t     stat
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ecpu_pkg::entry_t q [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic accept;
  logic take;

  assign instr.ready = (count != CNT_FULL);
  assign accept = instr.valid && instr.ready;
  assign take = pop && (count != '0);
  assign head = q[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full = (count == CNT_FULL);

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= '{opcode: instr.opcode, operand: instr.operand,
                     on_acc: instr.on_accumulator, target: instr.target_address,
                     pc: instr.current_pc, cls: ecpu_pkg::classify(instr.opcode)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({accept, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

@@ rtl/core/ecpu_back.sv @@
// Back end: holds A, X, Y, SP, flags and the stack page; executes the queue head.
// Depends on ecpu_pkg and ecpu_result_if.
module ecpu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [15:0]          cfg_data,
  input  ecpu_pkg::entry_t     head,
  input  ecpu_pkg::fstat_t     qstat,
  output logic                 pop,
  output ecpu_pkg::bstat_t     stat,
  ecpu_result_if.source        result
);
  logic [7:0]  acc, xr, yr, sp, flags;
  logic [7:0]  a_next, x_next, y_next, sp_next, p_next;
  logic [15:0] break_vector;
  logic [1:0]  step;
  logic        go, done, out_free;

  logic [7:0]  stack_mem [256];
  logic [255:0] written;
  logic [7:0]  rd_q, b0, b1, pb;
  logic        rd_v;
  logic        mem_we;
  logic [7:0]  push_data;

  logic [15:0] npc, ret_brk, ret_jsr;
  logic        wr, is_rmw, take;
  logic [7:0]  wd, src, rmw, mop, res, cmp_r, pt;
  logic [8:0]  sum9, diff9;

  logic        out_valid;
  logic [15:0] out_pc;
  logic        out_wr;
  logic [7:0]  out_wd, out_a, out_x, out_y, out_sp, out_p;

  assign out_free = !out_valid || result.ready;
  assign go = qstat.valid && out_free;
  assign done = go && (step == head.cls.last);
  assign pop = done;
  assign stat.mid = (step != 2'd0);
  assign stat.pop = done;
  assign mem_we = go && head.cls.is_push;
  assign pb = rd_v ? rd_q : 8'h00;

  assign ret_brk = head.pc + 16'd1;
  assign ret_jsr = head.pc - 16'd1;

  // Byte pushed at the current step; return addresses go high byte first.
  always_comb begin
    case (head.opcode)
      ecpu_pkg::OP_BRK: begin
        case (step)
          2'd0:    push_data = ret_brk[15:8];
          2'd1:    push_data = ret_brk[7:0];
          default: push_data = flags | ecpu_pkg::FL_B | ecpu_pkg::FL_R;
        endcase
      end
      ecpu_pkg::OP_JSR: push_data = (step == 2'd0) ? ret_jsr[15:8] : ret_jsr[7:0];
      ecpu_pkg::OP_PHA: push_data = acc;
      default:          push_data = flags | ecpu_pkg::FL_B | ecpu_pkg::FL_R;
    endcase
  end

  always_comb begin
    src = head.on_acc ? acc : head.operand;
    mop = (head.opcode == ecpu_pkg::OP_SBC) ? ~head.operand : head.operand;
    sum9 = {1'b0, acc} + {1'b0, mop} + {8'h00, flags[0]};
    res = sum9[7:0];
    case (head.opcode)
      ecpu_pkg::OP_CPX: cmp_r = xr;
      ecpu_pkg::OP_CPY: cmp_r = yr;
      default:          cmp_r = acc;
    endcase
    diff9 = {1'b0, cmp_r} - {1'b0, head.operand};
  end

  always_comb begin
    a_next = acc;
    x_next = xr;
    y_next = yr;
    sp_next = sp;
    p_next = flags;
    pt = flags;
    npc = head.pc;
    wr = 1'b0;
    wd = 8'h00;
    rmw = 8'h00;
    is_rmw = 1'b0;
    take = 1'b0;
    if (go && head.cls.is_push) begin
      sp_next = sp - 8'd1;
    end
    if (go && head.cls.is_pull && !done) begin
      sp_next = sp + 8'd1;
    end
    if (done) begin
      case (head.opcode)
        ecpu_pkg::OP_ADC, ecpu_pkg::OP_SBC: begin
          pt[0] = sum9[8];
          pt[6] = (~(acc ^ mop) & (acc ^ res)) >> 7 != 8'h00;
          a_next = res;
          p_next = ecpu_pkg::with_nz(pt, res);
        end
        ecpu_pkg::OP_AND: begin
          a_next = acc & head.operand;
          p_next = ecpu_pkg::with_nz(flags, acc & head.operand);
        end
        ecpu_pkg::OP_EOR: begin
          a_next = acc ^ head.operand;
          p_next = ecpu_pkg::with_nz(flags, acc ^ head.operand);
        end
        ecpu_pkg::OP_ORA: begin
          a_next = acc | head.operand;
          p_next = ecpu_pkg::with_nz(flags, acc | head.operand);
        end
        ecpu_pkg::OP_ASL: begin
          pt[0] = src[7];
          rmw = {src[6:0], 1'b0};
          is_rmw = 1'b1;
        end
        ecpu_pkg::OP_LSR: begin
          pt[0] = src[0];
          rmw = {1'b0, src[7:1]};
          is_rmw = 1'b1;
        end
        ecpu_pkg::OP_ROL: begin
          pt[0] = src[7];
          rmw = {src[6:0], flags[0]};
          is_rmw = 1'b1;
        end
        ecpu_pkg::OP_ROR: begin
          pt[0] = src[0];
          rmw = {flags[0], src[7:1]};
          is_rmw = 1'b1;
        end
        ecpu_pkg::OP_INC: begin
          rmw = src + 8'd1;
          is_rmw = 1'b1;
        end
        ecpu_pkg::OP_DEC: begin
          rmw = src - 8'd1;
          is_rmw = 1'b1;
        end
        ecpu_pkg::OP_BCC: take = !flags[0];
        ecpu_pkg::OP_BCS: take = flags[0];
        ecpu_pkg::OP_BEQ: take = flags[1];
        ecpu_pkg::OP_BNE: take = !flags[1];
        ecpu_pkg::OP_BMI: take = flags[7];
        ecpu_pkg::OP_BPL: take = !flags[7];
        ecpu_pkg::OP_BVC: take = !flags[6];
        ecpu_pkg::OP_BVS: take = flags[6];
        ecpu_pkg::OP_BIT: begin
          p_next = {head.operand[7:6], flags[5:2], ((acc & head.operand) == 8'h00), flags[0]};
        end
        ecpu_pkg::OP_BRK: begin
          p_next = flags | ecpu_pkg::FL_I;
          npc = break_vector;
        end
        ecpu_pkg::OP_CLC: p_next[0] = 1'b0;
        ecpu_pkg::OP_CLD: p_next[3] = 1'b0;
        ecpu_pkg::OP_CLI: p_next[2] = 1'b0;
        ecpu_pkg::OP_CLV: p_next[6] = 1'b0;
        ecpu_pkg::OP_SEC: p_next[0] = 1'b1;
        ecpu_pkg::OP_SED: p_next[3] = 1'b1;
        ecpu_pkg::OP_SEI: p_next[2] = 1'b1;
        ecpu_pkg::OP_CMP, ecpu_pkg::OP_CPX, ecpu_pkg::OP_CPY: begin
          p_next = ecpu_pkg::with_nz({flags[7:1], !diff9[8]}, diff9[7:0]);
        end
        ecpu_pkg::OP_DEX: begin
          x_next = xr - 8'd1;
          p_next = ecpu_pkg::with_nz(flags, xr - 8'd1);
        end
        ecpu_pkg::OP_DEY: begin
          y_next = yr - 8'd1;
          p_next = ecpu_pkg::with_nz(flags, yr - 8'd1);
        end
        ecpu_pkg::OP_INX: begin
          x_next = xr + 8'd1;
          p_next = ecpu_pkg::with_nz(flags, xr + 8'd1);
        end
        ecpu_pkg::OP_INY: begin
          y_next = yr + 8'd1;
          p_next = ecpu_pkg::with_nz(flags, yr + 8'd1);
        end
        ecpu_pkg::OP_JMP, ecpu_pkg::OP_JSR: npc = head.target;
        ecpu_pkg::OP_LDA: begin
          a_next = head.operand;
          p_next = ecpu_pkg::with_nz(flags, head.operand);
        end
        ecpu_pkg::OP_LDX: begin
          x_next = head.operand;
          p_next = ecpu_pkg::with_nz(flags, head.operand);
        end
        ecpu_pkg::OP_LDY: begin
          y_next = head.operand;
          p_next = ecpu_pkg::with_nz(flags, head.operand);
        end
        ecpu_pkg::OP_PLA: begin
          a_next = pb;
          p_next = ecpu_pkg::with_nz(flags, pb);
        end
        // B and the reserved bit never come from the stack.
        ecpu_pkg::OP_PLP: p_next = {pb[7:6], flags[5:4], pb[3:0]};
        ecpu_pkg::OP_RTI: begin
          p_next = {b0[7:6], flags[5:4], b0[3:0]};
          npc = {pb, b1};
        end
        ecpu_pkg::OP_RTS: npc = {pb, b0} + 16'd1;
        ecpu_pkg::OP_STA: begin
          wr = 1'b1;
          wd = acc;
        end
        ecpu_pkg::OP_STX: begin
          wr = 1'b1;
          wd = xr;
        end
        ecpu_pkg::OP_STY: begin
          wr = 1'b1;
          wd = yr;
        end
        ecpu_pkg::OP_TAX: begin
          x_next = acc;
          p_next = ecpu_pkg::with_nz(flags, acc);
        end
        ecpu_pkg::OP_TAY: begin
          y_next = acc;
          p_next = ecpu_pkg::with_nz(flags, acc);
        end
        ecpu_pkg::OP_TSX: begin
          x_next = sp;
          p_next = ecpu_pkg::with_nz(flags, sp);
        end
        ecpu_pkg::OP_TXA: begin
          a_next = xr;
          p_next = ecpu_pkg::with_nz(flags, xr);
        end
        ecpu_pkg::OP_TXS: sp_next = xr;
        ecpu_pkg::OP_TYA: begin
          a_next = yr;
          p_next = ecpu_pkg::with_nz(flags, yr);
        end
        default: p_next = flags;
      endcase
      if (is_rmw) begin
        p_next = ecpu_pkg::with_nz(pt, rmw);
        if (head.on_acc) begin
          a_next = rmw;
        end else begin
          wr = 1'b1;
          wd = rmw;
        end
      end
      if (take) begin
        npc = head.pc + {{8{head.operand[7]}}, head.operand};
      end
    end
  end

  // Stack page: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[sp] <= push_data;
    end
    if (go && head.cls.is_pull) begin
      rd_q <= stack_mem[sp + 8'd1];
      rd_v <= written[sp + 8'd1];
      if (step == 2'd1) begin
        b0 <= pb;
      end
      if (step == 2'd2) begin
        b1 <= pb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (mem_we) begin
      written[sp] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'h00;
      xr <= 8'h00;
      yr <= 8'h00;
      sp <= ecpu_pkg::SP_RESET;
      flags <= ecpu_pkg::FLAGS_RESET;
      break_vector <= 16'h0000;
      step <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      acc <= a_next;
      xr <= x_next;
      yr <= y_next;
      sp <= sp_next;
      flags <= p_next;
      if (cfg_write) begin
        break_vector <= cfg_data;
      end
      if (go) begin
        step <= done ? 2'd0 : step + 2'd1;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_pc <= npc;
      out_wr <= wr;
      out_wd <= wd;
      out_a <= a_next;
      out_x <= x_next;
      out_y <= y_next;
      out_sp <= sp_next;
      out_p <= p_next;
    end
  end

  assign result.valid = out_valid;
  assign result.next_pc = out_pc;
  assign result.mem_write = out_wr;
  assign result.mem_data = out_wd;
  assign result.acc_value = out_a;
  assign result.x_value = out_x;
  assign result.y_value = out_y;
  assign result.sp_value = out_sp;
  assign result.flags_value = out_p;
endmodule

@@ test/eight_bit_cpu_execute_unit_checker.sv @@
// Checker for the execute unit: watches the instruction and result channels,
// predicts each result from its own copy of the CPU state and compares field by field.
// Depends on ecpu_pkg and the two channel interfaces.
`timescale 1ns / 100ps
module eight_bit_cpu_execute_unit_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [15:0]   cfg_data,
  ecpu_instr_if.sink    instr_mon,
  ecpu_result_if.sink   result_mon,
  output int            fail_count,
  output int            pending
);

  typedef struct packed {
    logic [15:0] next_pc;
    logic        mem_write;
    logic [7:0]  mem_data;
    logic [7:0]  acc;
    logic [7:0]  xr;
    logic [7:0]  yr;
    logic [7:0]  sp;
    logic [7:0]  flags;
  } cpu_result_t;

  cpu_result_t expected_results[$];
  logic [7:0]  acc_q, x_q, y_q, sp_q, p_q;
  logic [7:0]  stack_mem [256];
  logic [15:0] brk_vector;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  function automatic void set_nz(input logic [7:0] v);
    p_q[7] = v[7];
    p_q[1] = (v == 8'h00);
  endfunction

  function automatic void push(input logic [7:0] v);
    stack_mem[sp_q] = v;
    sp_q = sp_q - 8'd1;
  endfunction

  function automatic logic [7:0] pull();
    sp_q = sp_q + 8'd1;
    return stack_mem[sp_q];
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] s;
    logic [7:0] r;
    s = {1'b0, acc_q} + {1'b0, m} + {8'd0, p_q[0]};
    r = s[7:0];
    p_q[0] = s[8];
    p_q[6] = (~(acc_q ^ m) & (acc_q ^ r) & 8'h80) != 0;
    acc_q = r;
    set_nz(r);
  endfunction

  function automatic void compare(input logic [7:0] r, input logic [7:0] m);
    p_q[0] = (r >= m);
    set_nz(r - m);
  endfunction

  function automatic void pull_status();
    logic [7:0] keep, v;
    keep = p_q & (ecpu_pkg::FL_B | ecpu_pkg::FL_R);
    v = pull();
    p_q = (v & ~(ecpu_pkg::FL_B | ecpu_pkg::FL_R)) | keep;
  endfunction

  function automatic cpu_result_t execute(input logic [5:0] opc, input logic [7:0] m,
                                          input logic on_a, input logic [15:0] tgt,
                                          input logic [15:0] pc);
    cpu_result_t r;
    logic [15:0] npc, ret;
    logic        wr, rmw_op, is_br, take;
    logic [7:0]  wd, rmw, src, lo, hi;
    npc = pc; wr = 0; wd = 0; rmw_op = 0; rmw = 0; is_br = 0; take = 0;
    src = on_a ? acc_q : m;
    case (opc)
      ecpu_pkg::OP_ADC: add_carry(m);
      ecpu_pkg::OP_AND: begin acc_q &= m; set_nz(acc_q); end
      ecpu_pkg::OP_ASL: begin p_q[0] = src[7]; rmw = src << 1; rmw_op = 1; end
      ecpu_pkg::OP_BCC: begin is_br = 1; take = !p_q[0]; end
      ecpu_pkg::OP_BCS: begin is_br = 1; take = p_q[0]; end
      ecpu_pkg::OP_BEQ: begin is_br = 1; take = p_q[1]; end
      ecpu_pkg::OP_BIT: begin
        p_q[1] = (acc_q & m) == 0;
        p_q[6] = m[6];
        p_q[7] = m[7];
      end
      ecpu_pkg::OP_BMI: begin is_br = 1; take = p_q[7]; end
      ecpu_pkg::OP_BNE: begin is_br = 1; take = !p_q[1]; end
      ecpu_pkg::OP_BPL: begin is_br = 1; take = !p_q[7]; end
      ecpu_pkg::OP_BRK: begin
        ret = pc + 16'd1;
        push(ret[15:8]);
        push(ret[7:0]);
        push(p_q | ecpu_pkg::FL_B | ecpu_pkg::FL_R);
        p_q |= ecpu_pkg::FL_I;
        npc = brk_vector;
      end
      ecpu_pkg::OP_BVC: begin is_br = 1; take = !p_q[6]; end
      ecpu_pkg::OP_BVS: begin is_br = 1; take = p_q[6]; end
      ecpu_pkg::OP_CLC: p_q[0] = 0;
      ecpu_pkg::OP_CLD: p_q[3] = 0;
      ecpu_pkg::OP_CLI: p_q[2] = 0;
      ecpu_pkg::OP_CLV: p_q[6] = 0;
      ecpu_pkg::OP_CMP: compare(acc_q, m);
      ecpu_pkg::OP_CPX: compare(x_q, m);
      ecpu_pkg::OP_CPY: compare(y_q, m);
      ecpu_pkg::OP_DEC: begin rmw = src - 8'd1; rmw_op = 1; end
      ecpu_pkg::OP_DEX: begin x_q--; set_nz(x_q); end
      ecpu_pkg::OP_DEY: begin y_q--; set_nz(y_q); end
      ecpu_pkg::OP_EOR: begin acc_q ^= m; set_nz(acc_q); end
      ecpu_pkg::OP_INC: begin rmw = src + 8'd1; rmw_op = 1; end
      ecpu_pkg::OP_INX: begin x_q++; set_nz(x_q); end
      ecpu_pkg::OP_INY: begin y_q++; set_nz(y_q); end
      ecpu_pkg::OP_JMP: npc = tgt;
      ecpu_pkg::OP_JSR: begin
        ret = pc - 16'd1;
        push(ret[15:8]);
        push(ret[7:0]);
        npc = tgt;
      end
      ecpu_pkg::OP_LDA: begin acc_q = m; set_nz(m); end
      ecpu_pkg::OP_LDX: begin x_q = m; set_nz(m); end
      ecpu_pkg::OP_LDY: begin y_q = m; set_nz(m); end
      ecpu_pkg::OP_LSR: begin p_q[0] = src[0]; rmw = src >> 1; rmw_op = 1; end
      ecpu_pkg::OP_ORA: begin acc_q |= m; set_nz(acc_q); end
      ecpu_pkg::OP_PHA: push(acc_q);
      ecpu_pkg::OP_PHP: push(p_q | ecpu_pkg::FL_B | ecpu_pkg::FL_R);
      ecpu_pkg::OP_PLA: begin acc_q = pull(); set_nz(acc_q); end
      ecpu_pkg::OP_PLP: pull_status();
      ecpu_pkg::OP_ROL: begin rmw = {src[6:0], p_q[0]}; p_q[0] = src[7]; rmw_op = 1; end
      ecpu_pkg::OP_ROR: begin rmw = {p_q[0], src[7:1]}; p_q[0] = src[0]; rmw_op = 1; end
      ecpu_pkg::OP_RTI: begin pull_status(); lo = pull(); hi = pull(); npc = {hi, lo}; end
      ecpu_pkg::OP_RTS: begin lo = pull(); hi = pull(); npc = {hi, lo} + 16'd1; end
      ecpu_pkg::OP_SBC: add_carry(~m);
      ecpu_pkg::OP_SEC: p_q[0] = 1;
      ecpu_pkg::OP_SED: p_q[3] = 1;
      ecpu_pkg::OP_SEI: p_q[2] = 1;
      ecpu_pkg::OP_STA: begin wr = 1; wd = acc_q; end
      ecpu_pkg::OP_STX: begin wr = 1; wd = x_q; end
      ecpu_pkg::OP_STY: begin wr = 1; wd = y_q; end
      ecpu_pkg::OP_TAX: begin x_q = acc_q; set_nz(x_q); end
      ecpu_pkg::OP_TAY: begin y_q = acc_q; set_nz(y_q); end
      ecpu_pkg::OP_TSX: begin x_q = sp_q; set_nz(x_q); end
      ecpu_pkg::OP_TXA: begin acc_q = x_q; set_nz(acc_q); end
      ecpu_pkg::OP_TXS: sp_q = x_q;
      ecpu_pkg::OP_TYA: begin acc_q = y_q; set_nz(acc_q); end
      default: ;
    endcase
    if (rmw_op) begin
      set_nz(rmw);
      if (on_a) acc_q = rmw;
      else begin
        wr = 1;
        wd = rmw;
      end
    end
    if (is_br && take) npc = pc + {{8{m[7]}}, m};
    r = '{next_pc: npc, mem_write: wr, mem_data: wr ? wd : 8'h00, acc: acc_q, xr: x_q,
          yr: y_q, sp: sp_q, flags: p_q};
    return r;
  endfunction

  always @(posedge clk) begin
    cpu_result_t want;
    if (rst) begin
      acc_q = 0; x_q = 0; y_q = 0; sp_q = ecpu_pkg::SP_RESET; p_q = ecpu_pkg::FLAGS_RESET;
      brk_vector <= 0;
      for (int i = 0; i < 256; i++) stack_mem[i] = 8'h00;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) brk_vector <= cfg_data;
      if (instr_mon.valid && instr_mon.ready)
        expected_results.push_back(execute(instr_mon.opcode, instr_mon.operand,
                                           instr_mon.on_accumulator,
                                           instr_mon.target_address, instr_mon.current_pc));
      if (result_mon.valid && result_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (result_mon.next_pc !== want.next_pc)
            report_mismatch("next_pc", result_mon.next_pc, want.next_pc);
          if (result_mon.mem_write !== want.mem_write)
            report_mismatch("mem_write", result_mon.mem_write, want.mem_write);
          if (result_mon.mem_data !== want.mem_data)
            report_mismatch("mem_data", result_mon.mem_data, want.mem_data);
          if (result_mon.acc_value !== want.acc)
            report_mismatch("acc_value", result_mon.acc_value, want.acc);
          if (result_mon.x_value !== want.xr)
            report_mismatch("x_value", result_mon.x_value, want.xr);
          if (result_mon.y_value !== want.yr)
            report_mismatch("y_value", result_mon.y_value, want.yr);
          if (result_mon.sp_value !== want.sp)
            report_mismatch("sp_value", result_mon.sp_value, want.sp);
          if (result_mon.flags_value !== want.flags)
            report_mismatch("flags_value", result_mon.flags_value, want.flags);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ test/eight_bit_cpu_execute_unit_tb.sv @@
// Testbench top for the execute unit: clock, reset, break-vector writes and
// instruction stimulus under several idling phases; checking sits in the checker module.
// Depends on ecpu_pkg, the channel interfaces, the unit and its checker.
`timescale 1ns / 100ps
module eight_bit_cpu_execute_unit_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  ecpu_instr_if  instr();
  ecpu_result_if result();

  eight_bit_cpu_execute_unit dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .instr(instr), .result(result)
  );

  eight_bit_cpu_execute_unit_checker checker_i (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .instr_mon(instr), .result_mon(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("eight_bit_cpu_execute_unit verification failed");
      $finish;
    end
  end

  // Receiver stall is redrawn every falling edge.
  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // leaving valid high so the next beat can follow with no gap.
  task automatic send_instr(input ecpu_pkg::op_t opc, input logic [7:0] m, input logic on_a,
                            input logic [15:0] tgt, input logic [15:0] pc);
    while ($urandom_range(99) < send_idle_pct) begin
      instr.valid <= 0;
      @(negedge clk);
    end
    instr.valid <= 1;
    instr.opcode <= opc;
    instr.operand <= m;
    instr.on_accumulator <= on_a;
    instr.target_address <= tgt;
    instr.current_pc <= pc;
    // Ready only moves at rising edges, so it is stable here.
    while (!instr.ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_rand(input ecpu_pkg::op_t opc);
    send_instr(opc, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_raw(input logic [5:0] opc);
    send_rand(ecpu_pkg::op_t'(opc));
  endtask

  task automatic drain_and_write(input logic [15:0] vec);
    instr.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_write <= 1;
    cfg_data <= vec;
    @(negedge clk);
    cfg_write <= 0;
  endtask

  // Random operation, biased toward well-formed stack use so pulls see pushed data.
  task automatic random_instr();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      send_rand(ecpu_pkg::OP_JSR);
      send_raw(6'($urandom_range(55)));
      send_rand(ecpu_pkg::OP_RTS);
    end else if (sel < 14) begin
      send_rand(ecpu_pkg::OP_PHA);
      send_rand(ecpu_pkg::OP_PHP);
      send_rand(ecpu_pkg::OP_PLP);
      send_rand(ecpu_pkg::OP_PLA);
    end else if (sel < 18) begin
      send_rand(ecpu_pkg::OP_BRK);
      send_rand(ecpu_pkg::OP_RTI);
    end else if (sel < 22) begin
      send_raw(6'($urandom_range(63)));
    end else begin
      send_raw(6'($urandom_range(55)));
    end
  endtask

  initial begin
    logic [15:0] vectors[4];
    int          idle_modes[4][2];
    vectors = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1234};
    idle_modes = '{'{0, 0}, '{75, 0}, '{0, 75}, '{16, 16}};
    rst = 1;
    cfg_write = 0;
    cfg_data = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    instr.valid = 0;
    instr.opcode = 0;
    instr.operand = 0;
    instr.on_accumulator = 0;
    instr.target_address = 0;
    instr.current_pc = 0;
    result.ready = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part: edge operands, stack from reset, compares, ADC/SBC overflow,
    // branches both ways, and the accumulator flag on non-shift operations.
    send_instr(ecpu_pkg::OP_LDA, 8'h7F, 1, 16'hFFFF, 16'h0000);
    send_instr(ecpu_pkg::OP_ADC, 8'h01, 0, 16'h0000, 16'hFFFF);
    send_instr(ecpu_pkg::OP_SBC, 8'hFF, 1, 16'h0000, 16'h0001);
    send_instr(ecpu_pkg::OP_CMP, 8'h80, 0, 16'h0000, 16'h1000);
    send_instr(ecpu_pkg::OP_CPX, 8'h01, 0, 16'h0000, 16'h1000);
    send_instr(ecpu_pkg::OP_CPY, 8'h00, 0, 16'h0000, 16'h1000);
    send_instr(ecpu_pkg::OP_BMI, 8'h80, 0, 16'h0000, 16'h0010);
    send_instr(ecpu_pkg::OP_BPL, 8'h7F, 0, 16'h0000, 16'hFFF0);
    send_instr(ecpu_pkg::OP_BNE, 8'hFF, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_PLA, 8'h00, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_JSR, 8'h00, 0, 16'hABCD, 16'h0000);
    send_instr(ecpu_pkg::OP_RTS, 8'h00, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_BRK, 8'h00, 0, 16'h0000, 16'hFFFF);
    send_instr(ecpu_pkg::OP_RTI, 8'h00, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_PHP, 8'h00, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_PLP, 8'h00, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_ROR, 8'h01, 1, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_ROL, 8'h80, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_INC, 8'hFF, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_DEC, 8'h00, 1, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_TSX, 8'h00, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_TXS, 8'h00, 0, 16'h0000, 16'h0000);
    send_instr(ecpu_pkg::OP_BIT, 8'hC0, 0, 16'h0000, 16'h0000);
    send_raw(6'd63);
    for (int op = 0; op < 64; op++) send_raw(op[5:0]);

    // Each phase uses a new break vector and idling mode.
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_write(vectors[ph]);
      send_idle_pct = idle_modes[ph][0];
      recv_stall_pct = idle_modes[ph][1];
      for (int i = 0; i < 250; i++) random_instr();
    end

    instr.valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("eight_bit_cpu_execute_unit verification clean");
    else
      $display("eight_bit_cpu_execute_unit verification failed");
    $finish;
  end

endmodule
